// ===== rtl/core/image_convolution_3x3_unit_macros.svh =====
// assertion macros shared by the 3x3 convolution rtl
// no dependencies; included by files that carry concurrent checks
`ifndef IMAGE_CONVOLUTION_3X3_UNIT_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define C3X3_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("c3x3 check failed");
`define C3X3_NEVER(lbl, clk, rst, cond) \
  `C3X3_ASSERT(lbl, clk, rst, !(cond))
`else
`define C3X3_ASSERT(lbl, clk, rst, prop)
`define C3X3_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/core/c3x3_pkg.sv =====
// shared types, constants and kernel weights of the 3x3 convolution unit
// no dependencies
package c3x3_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int FSEL_W     = 3;
  localparam int FW_W       = 13;
  localparam int FH_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int TERM_W     = 13;
  localparam int SUM_W      = 14;
  localparam int NUM_TAPS   = 9;
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_AW      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER = 2'd0,
    CFG_COLOR  = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_index_t;

  localparam logic [FSEL_W-1:0] FILT_SMOOTH  = 3'd0;
  localparam logic [FSEL_W-1:0] FILT_BLUR    = 3'd1;
  localparam logic [FSEL_W-1:0] FILT_SHARPEN = 3'd2;
  localparam logic [FSEL_W-1:0] FILT_MEANREM = 3'd3;
  localparam logic [FSEL_W-1:0] FILT_EMBOSS  = 3'd4;
  localparam logic [FSEL_W-1:0] FILT_COUNT   = 3'd5;

  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [OQ_AW:0] count;
    logic           full;
  } oq_status_t;

  localparam logic signed [4:0] K_SMOOTH  [NUM_TAPS] =
    '{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1};
  localparam logic signed [4:0] K_BLUR    [NUM_TAPS] =
    '{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1};
  localparam logic signed [4:0] K_SHARPEN [NUM_TAPS] =
    '{5'sd0, -5'sd2, 5'sd0, -5'sd2, 5'sd11, -5'sd2, 5'sd0, -5'sd2, 5'sd0};
  localparam logic signed [4:0] K_MEANREM [NUM_TAPS] =
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1};
  localparam logic signed [4:0] K_EMBOSS  [NUM_TAPS] =
    '{5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, -5'sd1, 5'sd0};

  function automatic logic signed [4:0] kern_weight(input logic [FSEL_W-1:0] sel,
                                                    input logic [3:0] idx);
    logic signed [4:0] w;
    w = 5'sd0;
    case (sel)
      FILT_SMOOTH:  w = K_SMOOTH[idx];
      FILT_BLUR:    w = K_BLUR[idx];
      FILT_SHARPEN: w = K_SHARPEN[idx];
      FILT_MEANREM: w = K_MEANREM[idx];
      FILT_EMBOSS:  w = K_EMBOSS[idx];
      default:      w = 5'sd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/c3x3_cell.sv =====
// one window tap: holds a pixel, hands it to its neighbor, weights its channels
// depends on c3x3_pkg
module c3x3_cell #(
  parameter int TAP = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift_en,
  input  logic [c3x3_pkg::FSEL_W-1:0]    sel,
  input  logic [c3x3_pkg::PIX_W-1:0]     din,
  output logic [c3x3_pkg::PIX_W-1:0]     dout,
  output c3x3_pkg::term_t                terms [c3x3_pkg::NUM_CH]
);
  import c3x3_pkg::*;

  logic signed [4:0] weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift_en) begin
      dout <= din;
    end
  end

  assign weight = kern_weight(sel, 4'(TAP));

  always_comb begin
    logic signed [TERM_W:0] prod;
    for (int k = 0; k < NUM_CH; k++) begin
      prod = weight * $signed({1'b0, dout[k*CH_W +: CH_W]});
      terms[k] = prod[TERM_W-1:0];
    end
  end

endmodule

// ===== rtl/core/c3x3_linebuf.sv =====
// two line stores: the pixel one and two rows back, one entry per column
// depends on c3x3_pkg
module c3x3_linebuf #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [c3x3_pkg::PIX_W-1:0] rd_upper,
  output logic [c3x3_pkg::PIX_W-1:0] rd_lower,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [c3x3_pkg::PIX_W-1:0] wr_upper,
  input  logic [c3x3_pkg::PIX_W-1:0] wr_lower
);
  import c3x3_pkg::*;

  logic [PIX_W-1:0] mem_upper [DEPTH];
  logic [PIX_W-1:0] mem_lower [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr] <= wr_upper;
      mem_lower[wr_addr] <= wr_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper <= mem_upper[rd_addr];
      rd_lower <= mem_lower[rd_addr];
    end
  end

endmodule

// ===== rtl/core/c3x3_outq.sv =====
// result queue between the filter pipeline and the output channel
// depends on c3x3_pkg
module c3x3_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  c3x3_pkg::result_t      push_data,
  input  logic                   pop,
  output logic                   not_empty,
  output c3x3_pkg::result_t      head,
  output c3x3_pkg::oq_status_t   status
);
  import c3x3_pkg::*;

  result_t        slots [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (OQ_AW+1)'(push) - (OQ_AW+1)'(pop);
    end
  end

  assign not_empty    = (count != '0);
  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == (OQ_AW+1)'(OQ_DEPTH));

endmodule

// ===== rtl/core/image_convolution_3x3_unit.sv =====
// top level of the streaming 3x3 convolution filter
// depends on c3x3_pkg, c3x3_cell, c3x3_linebuf, c3x3_outq and the macros header
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    chan_red chan_green chan_blue is_flush
//  out       output     out_valid / out_ready  out_red out_green out_blue frame_last
//  cfg       input      cfg_we (no wait)       cfg_index cfg_data
//
// one pixel per clock while in_ready stays high; a pixel passes the line store read
// (stage a), the window shift (stage b) and the weighted sum register (stage c); divide/clamp
// feeds the queue write, after which out_valid rises
// the line store port and the nine-cell window set that rate
// in_ready drops only when the eight-entry result queue plus the items in flight
// would overflow, so input keeps flowing while a result waits on out_ready
// synchronous active-high reset; line stores need no clearing pass
`include "image_convolution_3x3_unit_macros.svh"
module image_convolution_3x3_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [c3x3_pkg::CH_W-1:0]       chan_red,
  input  logic [c3x3_pkg::CH_W-1:0]       chan_green,
  input  logic [c3x3_pkg::CH_W-1:0]       chan_blue,
  input  logic                            is_flush,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [c3x3_pkg::CH_W-1:0]       out_red,
  output logic [c3x3_pkg::CH_W-1:0]       out_green,
  output logic [c3x3_pkg::CH_W-1:0]       out_blue,
  output logic                            frame_last,
  input  logic                            cfg_we,
  input  logic [c3x3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c3x3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import c3x3_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic [FSEL_W-1:0] filter_select;
  logic              color_mode;
  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;

  // input position; the flush tail runs the row up to height plus one
  logic [CW-1:0]     in_column;
  logic [FH_W:0]     in_row;

  // effective frame limits, minus one
  logic [CW-1:0]     wm1;
  logic [FH_W-1:0]   hm1;

  // per-transfer decode
  logic              in_xfer;
  logic              in_frame;
  logic              ignore_item;
  logic              emit;
  logic [FH_W-1:0]   orow;
  logic [CW-1:0]     ocol;
  logic              interior;
  logic              is_last;
  logic [PIX_W-1:0]  px;

  // stage a: line store data arrives
  logic              a_valid;
  logic              a_emit;
  logic              a_interior;
  logic              a_last;
  logic              a_top_en;
  logic              a_mid_en;
  logic [CW-1:0]     a_col;
  logic [PIX_W-1:0]  a_px;
  logic [PIX_W-1:0]  rd_upper;
  logic [PIX_W-1:0]  rd_lower;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;

  // stage b: window holds the neighborhood
  logic              b_valid;
  logic              b_interior;
  logic              b_last;
  logic [PIX_W-1:0]  tap_pix   [NUM_TAPS];
  logic [PIX_W-1:0]  tap_in    [NUM_TAPS];
  term_t             tap_terms [NUM_TAPS][NUM_CH];
  sum_t              b_sum     [NUM_CH];

  // stage c: sums registered
  logic              c_valid;
  logic              c_interior;
  logic              c_last;
  logic [PIX_W-1:0]  c_centre;
  sum_t              c_sum [NUM_CH];
  result_t           c_result;

  // result queue
  oq_status_t        q_stat;
  result_t           q_head;
  logic [OQ_AW+1:0]  occupancy;

  // effective width and height
  always_comb begin
    int fw;
    int fh;
    fw = int'(frame_width);
    fh = int'(frame_height);
    if (fw < 3) fw = 3;
    if (fw > MAX_WIDTH) fw = MAX_WIDTH;
    if (fh < 3) fh = 3;
    wm1 = CW'(fw - 1);
    hm1 = FH_W'(fh - 1);
  end

  // credit check: queue entries plus every result still in the pipeline
  assign occupancy = (OQ_AW+2)'(q_stat.count) + (OQ_AW+2)'(a_valid && a_emit)
                   + (OQ_AW+2)'(b_valid) + (OQ_AW+2)'(c_valid);
  assign in_ready  = (occupancy < (OQ_AW+2)'(OQ_DEPTH));
  assign in_xfer   = in_valid && in_ready;

  // decode the item against the current position
  always_comb begin
    in_frame    = (in_row <= {1'b0, hm1});
    ignore_item = in_frame && is_flush;
    emit        = (in_row >= 17'd2) || ((in_row == 17'd1) && (in_column != '0));
    if (in_column == '0) begin
      orow = FH_W'(in_row - 17'd2);
      ocol = wm1;
    end else begin
      orow = FH_W'(in_row - 17'd1);
      ocol = in_column - 1'b1;
    end
    interior = (filter_select < FILT_COUNT) && (orow >= 16'd1) && (orow < hm1)
            && (ocol != '0) && (ocol < wm1);
    is_last  = emit && (orow == hm1) && (ocol == wm1);
    // late pixels and flush items shift in zeros
    px = '0;
    if (in_frame && !is_flush) begin
      px[CH_W-1:0] = chan_red;
      if (color_mode) begin
        px[2*CH_W-1:CH_W]   = chan_green;
        px[3*CH_W-1:2*CH_W] = chan_blue;
      end
    end
  end

  // configuration writes and input position; any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_select <= FILT_SMOOTH;
      color_mode    <= 1'b0;
      frame_width   <= 13'd640;
      frame_height  <= 16'd480;
      in_column     <= '0;
      in_row        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FILTER: filter_select <= cfg_data[FSEL_W-1:0];
        CFG_COLOR:  color_mode    <= cfg_data[0];
        CFG_WIDTH:  frame_width   <= cfg_data[FW_W-1:0];
        CFG_HEIGHT: frame_height  <= cfg_data[FH_W-1:0];
      endcase
      in_column <= '0;
      in_row    <= '0;
    end else if (in_xfer && !ignore_item) begin
      if (is_last) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (in_column == wm1) begin
        in_column <= '0;
        in_row    <= in_row + 17'd1;
      end else begin
        in_column <= in_column + 1'b1;
      end
    end
  end

  // stage a control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_xfer && !ignore_item;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_emit     <= emit;
      a_interior <= interior;
      a_last     <= is_last;
      a_top_en   <= (in_row >= 17'd2);
      a_mid_en   <= (in_row >= 17'd1);
      a_col      <= in_column;
      a_px       <= px;
    end
  end

  c3x3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk      (clk),
    .rd_en    (in_xfer),
    .rd_addr  (in_column),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower),
    .wr_en    (a_valid),
    .wr_addr  (a_col),
    .wr_upper (mid),
    .wr_lower (a_px)
  );

  // rows above the frame read as black
  assign top = a_top_en ? rd_upper : '0;
  assign mid = a_mid_en ? rd_lower : '0;

  // window: three rows of three cells, new pixels enter at the right end
  generate
    for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
        if (j == 2) begin : g_entry
          if (r == 0) begin : g_top
            assign tap_in[r*3+j] = top;
          end else if (r == 1) begin : g_mid
            assign tap_in[r*3+j] = mid;
          end else begin : g_bot
            assign tap_in[r*3+j] = a_px;
          end
        end else begin : g_link
          assign tap_in[r*3+j] = tap_pix[r*3+j+1];
        end
        c3x3_cell #(
          .TAP (r*3+j)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (a_valid),
          .sel      (filter_select),
          .din      (tap_in[r*3+j]),
          .dout     (tap_pix[r*3+j]),
          .terms    (tap_terms[r*3+j])
        );
      end
    end
  endgenerate

  // stage b control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_interior <= a_interior;
      b_last     <= a_last;
    end
  end

  // weighted sum per channel
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      b_sum[k] = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
        b_sum[k] = b_sum[k] + {tap_terms[t][k][TERM_W-1], tap_terms[t][k]};
      end
    end
  end

  // stage c
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      c_interior <= b_interior;
      c_last     <= b_last;
      c_centre   <= tap_pix[4];
      for (int k = 0; k < NUM_CH; k++) begin
        c_sum[k] <= b_sum[k];
      end
    end
  end

  // divide by reciprocal or shift, clamp; negative sums give zero; borders and unknown filters keep centre
  always_comb begin
    logic [SUM_W-2:0]  u;
    logic [25:0]       p9;
    logic [29:0]       p3;
    logic [SUM_W-2:0]  q;
    logic [CH_W-1:0]   ch [NUM_CH];
    for (int k = 0; k < NUM_CH; k++) begin
      u  = c_sum[k][SUM_W-2:0];
      p9 = u * 13'd7282;
      p3 = u * 16'd43691;
      case (filter_select)
        FILT_SMOOTH:  q = {3'b000, p9[25:16]};
        FILT_BLUR:    q = {4'b0000, u[SUM_W-2:4]};
        FILT_SHARPEN: q = p3[29:17];
        default:      q = u;
      endcase
      if (!c_interior) begin
        ch[k] = c_centre[k*CH_W +: CH_W];
      end else if (c_sum[k][SUM_W-1]) begin
        ch[k] = '0;
      end else if (q > 13'd255) begin
        ch[k] = 8'd255;
      end else begin
        ch[k] = q[CH_W-1:0];
      end
    end
    c_result.red   = ch[0];
    c_result.green = color_mode ? ch[1] : '0;
    c_result.blue  = color_mode ? ch[2] : '0;
    c_result.last  = c_last;
  end

  c3x3_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (c_valid),
    .push_data (c_result),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (q_head),
    .status    (q_stat)
  );

  assign out_red    = q_head.red;
  assign out_green  = q_head.green;
  assign out_blue   = q_head.blue;
  assign frame_last = q_head.last;

  // credit scheme keeps the queue from overflowing
  `C3X3_NEVER(a_queue_no_overflow, clk, rst, c_valid && q_stat.full)
  // a flush inside the frame leaves the pipeline untouched
  `C3X3_ASSERT(a_flush_ignored, clk, rst, in_xfer && is_flush && in_frame |=> !a_valid)
  // the end of frame only rides on an item that makes a result
  `C3X3_NEVER(a_last_needs_emit, clk, rst, a_valid && a_last && !a_emit)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the streaming 3x3 convolution filter
// depends on c3x3_pkg and image_convolution_3x3_unit; holds its own pixel predictor

// expected-result store and the filter predictor that fills it
class conv_scoreboard;
  localparam int STORE_DEPTH = 4096;

  logic [23:0] row_above2 [STORE_DEPTH];
  logic [23:0] row_above1 [STORE_DEPTH];
  logic [23:0] win [9];
  int unsigned col, row, sent;
  logic [2:0]  filt;
  logic        color;
  logic [12:0] width_reg;
  logic [15:0] height_reg;
  c3x3_pkg::result_t expected_q [$];
  int errors;

  int weights [5][9] = '{
    '{1, 1, 1, 1, 1, 1, 1, 1, 1},
    '{1, 2, 1, 2, 4, 2, 1, 2, 1},
    '{0, -2, 0, -2, 11, -2, 0, -2, 0},
    '{-1, -1, -1, -1, 9, -1, -1, -1, -1},
    '{0, 1, 0, 0, 0, 0, 0, -1, 0}
  };
  int divisor [5] = '{9, 16, 3, 1, 1};

  function new();
    errors = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      row_above2[i] = '0;
      row_above1[i] = '0;
    end
    filt = c3x3_pkg::FILT_SMOOTH;
    color = 1'b0;
    width_reg = 13'd640;
    height_reg = 16'd480;
    restart();
  endfunction

  function void restart();
    col = 0;
    row = 0;
    sent = 0;
    for (int k = 0; k < 9; k++) win[k] = '0;
  endfunction

  function int unsigned eff_w();
    if (width_reg < 3) return 3;
    if (width_reg > STORE_DEPTH) return STORE_DEPTH;
    return width_reg;
  endfunction

  function int unsigned eff_h();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function void write_reg(c3x3_pkg::cfg_index_t idx, logic [15:0] val);
    case (idx)
      c3x3_pkg::CFG_FILTER: filt = val[2:0];
      c3x3_pkg::CFG_COLOR:  color = val[0];
      c3x3_pkg::CFG_WIDTH:  width_reg = val[12:0];
      c3x3_pkg::CFG_HEIGHT: height_reg = val[15:0];
    endcase
    restart();
  endfunction

  function logic [7:0] conv_channel(int sh);
    int acc, q;
    acc = 0;
    for (int k = 0; k < 9; k++) acc += weights[filt][k] * int'((win[k] >> sh) & 8'hFF);
    q = acc / divisor[filt];
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // one accepted input transfer; may queue one expected result
  function void note_input(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
    int unsigned w, h, c, orow, ocol;
    logic [23:0] px, top, mid, ctr;
    c3x3_pkg::result_t res;
    logic is_last;
    w = eff_w();
    h = eff_h();
    if (row < h && fl) return;  // early flush is dropped
    c = (col >= STORE_DEPTH) ? 0 : col;
    px = '0;
    if (row < h) px = color ? {b, g, r} : {16'd0, r};
    top = (row >= 2) ? row_above2[c] : '0;
    mid = (row >= 1) ? row_above1[c] : '0;
    row_above2[c] = mid;
    row_above1[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (!(row >= 2 || (row == 1 && c >= 1))) begin
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row++;
      end
      return;
    end
    if (c == 0) begin
      ocol = w - 1;
      orow = row - 2;
    end else begin
      ocol = c - 1;
      orow = row - 1;
    end
    ctr = win[4];
    if (filt < c3x3_pkg::FILT_COUNT && orow >= 1 && orow + 2 <= h &&
        ocol >= 1 && ocol + 2 <= w) begin
      res.red = conv_channel(0);
      res.green = conv_channel(8);
      res.blue = conv_channel(16);
    end else begin
      // border pixel or unknown filter code: pass through
      res.red = ctr[7:0];
      res.green = ctr[15:8];
      res.blue = ctr[23:16];
    end
    if (!color) begin
      res.green = '0;
      res.blue = '0;
    end
    is_last = (longint'(sent) + 1 == longint'(w) * longint'(h));
    res.last = is_last;
    expected_q.push_back(res);
    if (is_last) restart();
    else begin
      sent++;
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row++;
      end
    end
  endfunction

  function void check_result(c3x3_pkg::result_t got);
    c3x3_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0b", $time,
               got.red, got.green, got.blue, got.last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.red !== want.red) begin
      $display("%0t: out_red expected %0d actual %0d", $time, want.red, got.red);
      errors++;
    end
    if (got.green !== want.green) begin
      $display("%0t: out_green expected %0d actual %0d", $time, want.green, got.green);
      errors++;
    end
    if (got.blue !== want.blue) begin
      $display("%0t: out_blue expected %0d actual %0d", $time, want.blue, got.blue);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: frame_last expected %0b actual %0b", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import c3x3_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] chan_red = '0, chan_green = '0, chan_blue = '0;
  logic is_flush = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic frame_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  conv_scoreboard pixels_sb = new();

  int send_idle_pct = 0;   // chance of a gap before each input transfer
  int recv_stall_pct = 0;  // chance of out_ready low per cycle
  int hold_cycles = 0;     // long receiver hold-off, counted down by the receiver

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  image_convolution_3x3_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .chan_red(chan_red), .chan_green(chan_green), .chan_blue(chan_blue),
    .is_flush(is_flush),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .frame_last(frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random stalls plus the long hold-off; results checked on each transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pixels_sb.check_result('{red: out_red, green: out_green, blue: out_blue,
                               last: frame_last});
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input transfer; valid stays up into the next call unless a gap is drawn
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    chan_red <= r;
    chan_green <= g;
    chan_blue <= b;
    is_flush <= fl;
    do @(posedge clk); while (!in_ready);
    pixels_sb.note_input(r, g, b, fl);
  endtask

  // drain everything the block owes, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    pixels_sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one frame: pixels with stray early flushes, then a tail of flushes or late pixels;
  // stop_at cuts the frame short to exercise a restart by register write
  task automatic run_frame(int early_pct, int unsigned stop_at);
    int unsigned npix, ntail, count;
    npix = pixels_sb.eff_w() * pixels_sb.eff_h();
    ntail = pixels_sb.eff_w() + 1;
    count = 0;
    for (int unsigned i = 0; i < npix + ntail; i++) begin
      if (count >= stop_at) return;
      if (i < npix && $urandom_range(99) < early_pct)
        send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
      if (i < npix)
        send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      else  // late pixel counts as flush
        send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(1));
      count++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: smallest color frame, sharpen, stray flush and late pixels
    write_cfg(CFG_FILTER, 16'(FILT_SHARPEN));
    write_cfg(CFG_COLOR, 16'd1);
    write_cfg(CFG_WIDTH, 16'd3);
    write_cfg(CFG_HEIGHT, 16'd3);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    for (int i = 0; i < 9; i++)
      send_pixel((i == 4) ? 8'd255 : 8'd0, (i == 4) ? 8'd0 : 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    for (int i = 0; i < 3; i++) send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    wait_idle();

    // width and height below range act as 3; unknown filter passes through
    write_cfg(CFG_WIDTH, 16'd1);
    write_cfg(CFG_HEIGHT, 16'd0);
    write_cfg(CFG_FILTER, 16'd7);
    write_cfg(CFG_COLOR, 16'd0);
    run_frame(0, 1000);
    wait_idle();

    // random frames across the idling phases
    for (int f = 0; f < 32; f++) begin
      case (f % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      write_cfg(CFG_FILTER, 16'($urandom_range(7)));
      write_cfg(CFG_COLOR, 16'($urandom_range(1)));
      write_cfg(CFG_WIDTH, 16'($urandom_range(3, 12)));
      write_cfg(CFG_HEIGHT, 16'($urandom_range(3, 6)));
      // receiver holds off while the sender keeps pushing, filling the block
      if (f == 5) hold_cycles = 300;
      if ($urandom_range(9) == 0) run_frame(10, $urandom_range(1, 30));
      else run_frame(10, 100000);
      // sender pause until every owed result is out
      wait_idle();
    end

    // width above range acts as the store depth; first row only, no result yet
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_cfg(CFG_FILTER, 16'(FILT_MEANREM));
    write_cfg(CFG_COLOR, 16'd1);
    write_cfg(CFG_WIDTH, 16'h1FFF);
    write_cfg(CFG_HEIGHT, 16'd3);
    run_frame(1, 300);
    wait_idle();
    // tallest frame, cut short after a few rows
    write_cfg(CFG_WIDTH, 16'd3);
    write_cfg(CFG_HEIGHT, 16'hFFFF);
    write_cfg(CFG_FILTER, 16'(FILT_EMBOSS));
    run_frame(0, 60);
    wait_idle();

    if (pixels_sb.errors == 0 && pixels_sb.expected_q.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // overall time limit
  initial begin
    #30000000;
    $display("tb_top failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/c3x3_pkg.sv
rtl/core/c3x3_cell.sv
rtl/core/c3x3_linebuf.sv
rtl/core/c3x3_outq.sv
rtl/core/image_convolution_3x3_unit.sv
tb/sv/tb_top.sv
